FILE: hw/rtl/st_pkg.sv
// Types, constants and byte-class helpers shared by the source tokenizer.
package st_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int LENGTH_WIDTH   = 16;
  localparam int LINE_WIDTH     = 24;
  localparam int BYTE_WIDTH     = 8;
  localparam int PREFIX_WIDTH   = 4 * BYTE_WIDTH;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_WIDTH-1:0] CHAR_NUL    = 8'h00;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CHAR_SLASH  = 8'h2F;
  localparam logic [BYTE_WIDTH-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [BYTE_WIDTH-1:0] CHAR_SEMI   = 8'h3B;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [BYTE_WIDTH-1:0] CHAR_RPAREN = 8'h29;
  localparam logic [BYTE_WIDTH-1:0] CHAR_EQ     = 8'h3D;
  localparam logic [BYTE_WIDTH-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LBRACE = 8'h7B;
  localparam logic [BYTE_WIDTH-1:0] CHAR_RBRACE = 8'h7D;

  // keyword prefixes, first character in the low byte
  localparam logic [PREFIX_WIDTH-1:0] WORD_EXIT = 32'h7469_7865;
  localparam logic [PREFIX_WIDTH-1:0] WORD_LET  = 32'h0074_656C;
  localparam logic [PREFIX_WIDTH-1:0] WORD_IF   = 32'h0000_6669;
  localparam logic [PREFIX_WIDTH-1:0] WORD_ELIF = 32'h6669_6C65;
  localparam logic [PREFIX_WIDTH-1:0] WORD_ELSE = 32'h6573_6C65;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_SLASH,
    MODE_LINE_COMMENT,
    MODE_BLOCK_COMMENT,
    MODE_BLOCK_STAR,
    MODE_ERROR
  } mode_t;

  typedef enum logic [4:0] {
    KIND_EXIT   = 5'd0,
    KIND_NUMBER = 5'd1,
    KIND_SEMI   = 5'd2,
    KIND_LPAREN = 5'd3,
    KIND_RPAREN = 5'd4,
    KIND_IDENT  = 5'd5,
    KIND_LET    = 5'd6,
    KIND_EQ     = 5'd7,
    KIND_PLUS   = 5'd8,
    KIND_STAR   = 5'd9,
    KIND_MINUS  = 5'd10,
    KIND_SLASH  = 5'd11,
    KIND_LBRACE = 5'd12,
    KIND_RBRACE = 5'd13,
    KIND_IF     = 5'd14,
    KIND_ELIF   = 5'd15,
    KIND_ELSE   = 5'd16,
    KIND_ERROR  = 5'd17
  } kind_t;

  typedef enum logic [1:0] {
    PREC_ADD  = 2'd0,
    PREC_MUL  = 2'd1,
    PREC_NONE = 2'd2
  } prec_t;

  typedef struct packed {
    kind_t                    kind;
    logic [LINE_WIDTH-1:0]     line;
    logic [POSITION_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0]   length;
    logic                      last;
  } token_t;

  function automatic logic is_space(input logic [BYTE_WIDTH-1:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [BYTE_WIDTH-1:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [BYTE_WIDTH-1:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  // single-character tokens; anything else is an error
  function automatic kind_t symbol_kind(input logic [BYTE_WIDTH-1:0] c);
    kind_t k;
    case (c)
      CHAR_SEMI:   k = KIND_SEMI;
      CHAR_LPAREN: k = KIND_LPAREN;
      CHAR_RPAREN: k = KIND_RPAREN;
      CHAR_EQ:     k = KIND_EQ;
      CHAR_PLUS:   k = KIND_PLUS;
      CHAR_STAR:   k = KIND_STAR;
      CHAR_MINUS:  k = KIND_MINUS;
      CHAR_LBRACE: k = KIND_LBRACE;
      CHAR_RBRACE: k = KIND_RBRACE;
      default:     k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic kind_t word_kind(input logic [PREFIX_WIDTH-1:0] prefix,
                                      input logic [LENGTH_WIDTH-1:0] len);
    kind_t k;
    k = KIND_IDENT;
    if (len == LENGTH_WIDTH'(4) && prefix == WORD_EXIT)      k = KIND_EXIT;
    else if (len == LENGTH_WIDTH'(3) && prefix == WORD_LET)  k = KIND_LET;
    else if (len == LENGTH_WIDTH'(2) && prefix == WORD_IF)   k = KIND_IF;
    else if (len == LENGTH_WIDTH'(4) && prefix == WORD_ELIF) k = KIND_ELIF;
    else if (len == LENGTH_WIDTH'(4) && prefix == WORD_ELSE) k = KIND_ELSE;
    return k;
  endfunction

  function automatic prec_t prec_of(input kind_t k);
    prec_t p;
    case (k)
      KIND_PLUS, KIND_MINUS: p = PREC_ADD;
      KIND_STAR, KIND_SLASH: p = PREC_MUL;
      default:               p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/source_tokenizer.sv
// Source tokenizer: byte-stream lexer with a small token output queue.
// The tokens a byte makes are written into the registered token queue when that byte is accepted.
// Throughput: one byte per cycle; one token per cycle is popped while m_tready is high, and
// s_tready drops while the four-entry token queue has fewer than two free entries.
// Two-token bytes never come back to back, so with m_tready high a byte is taken each cycle.
// Reset: synchronous; clears the queue, mode idle, position 0, line count 1.
module source_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [23:0] token_line, [55:24] token_start,
                                 // [71:56] token_length, [73:72] precedence_class, rest 0
  output logic [4:0]  m_tuser,   // [4:0] token_kind
  output logic        m_tlast    // last_of_run
);

  localparam int PW = st_pkg::POSITION_WIDTH;
  localparam int LW = st_pkg::LENGTH_WIDTH;
  localparam int NW = st_pkg::LINE_WIDTH;
  localparam int XW = st_pkg::PREFIX_WIDTH;
  localparam int BW = st_pkg::BYTE_WIDTH;

  st_pkg::mode_t   mode, mode_next;
  logic [XW-1:0]   prefix, prefix_next;
  logic [LW-1:0]   run_length, run_length_next;
  logic [PW-1:0]   run_start, run_start_next;
  logic [PW-1:0]   byte_position;
  logic [NW-1:0]   line_count;

  logic [BW-1:0]   c;
  logic            accept;
  logic            do_start;
  logic            newline;
  logic            extend;

  st_pkg::token_t  tok_b, tok_s, tok_f, tok0, tok1;
  logic            b_valid, s_valid, f_valid;
  logic [1:0]      n_tok;

  st_pkg::token_t              fifo [st_pkg::FIFO_DEPTH];
  logic [st_pkg::FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [st_pkg::FIFO_CW-1:0]  count;
  logic                        pop;
  st_pkg::token_t              head;

  assign c      = s_tdata;
  assign accept = s_tvalid && s_tready;

  // mode transition and run tracking
  always_comb begin
    mode_next       = mode;
    prefix_next     = prefix;
    run_length_next = run_length;
    run_start_next  = run_start;
    do_start        = 1'b0;
    newline         = 1'b0;
    extend          = 1'b0;
    unique case (mode)
      st_pkg::MODE_IDLE: do_start = 1'b1;
      st_pkg::MODE_IDENT: begin
        if (st_pkg::is_alpha(c) || st_pkg::is_digit(c)) extend = 1'b1;
        else do_start = 1'b1;
      end
      st_pkg::MODE_NUM: begin
        if (st_pkg::is_digit(c)) extend = 1'b1;
        else do_start = 1'b1;
      end
      st_pkg::MODE_SLASH: begin
        if (c == st_pkg::CHAR_SLASH) mode_next = st_pkg::MODE_LINE_COMMENT;
        else if (c == st_pkg::CHAR_STAR) mode_next = st_pkg::MODE_BLOCK_COMMENT;
        else do_start = 1'b1;
      end
      st_pkg::MODE_LINE_COMMENT: begin
        if (c == st_pkg::CHAR_NUL) begin
          mode_next = st_pkg::MODE_ERROR;
        end else if (c == st_pkg::CHAR_LF) begin
          mode_next = st_pkg::MODE_IDLE;
          newline   = 1'b1;
        end
      end
      st_pkg::MODE_BLOCK_COMMENT, st_pkg::MODE_BLOCK_STAR: begin
        if (c == st_pkg::CHAR_NUL) mode_next = st_pkg::MODE_ERROR;
        else if (c == st_pkg::CHAR_STAR) mode_next = st_pkg::MODE_BLOCK_STAR;
        else if (c == st_pkg::CHAR_SLASH && mode == st_pkg::MODE_BLOCK_STAR)
          mode_next = st_pkg::MODE_IDLE;
        else mode_next = st_pkg::MODE_BLOCK_COMMENT;
      end
      st_pkg::MODE_ERROR: mode_next = st_pkg::MODE_ERROR;
    endcase

    if (extend) begin
      if (run_length < LW'(4))
        prefix_next = prefix | (XW'(c) << {run_length[1:0], 3'b000});
      if (run_length != {LW{1'b1}})
        run_length_next = run_length + LW'(1);
    end

    // byte handled from idle, possibly right after a pending token was closed
    if (do_start) begin
      mode_next = st_pkg::MODE_IDLE;
      if (st_pkg::is_space(c)) begin
        newline = (c == st_pkg::CHAR_LF);
      end else if (st_pkg::is_alpha(c) || st_pkg::is_digit(c)) begin
        mode_next       = st_pkg::is_alpha(c) ? st_pkg::MODE_IDENT : st_pkg::MODE_NUM;
        run_start_next  = byte_position;
        prefix_next     = XW'(c);
        run_length_next = LW'(1);
      end else if (c == st_pkg::CHAR_SLASH) begin
        mode_next      = st_pkg::MODE_SLASH;
        run_start_next = byte_position;
      end else if (st_pkg::symbol_kind(c) == st_pkg::KIND_ERROR) begin
        mode_next = st_pkg::MODE_ERROR;
      end
    end
  end

  // tokens made by this byte: closed run, symbol or error, end-of-source flush
  always_comb begin
    b_valid = do_start && (mode == st_pkg::MODE_IDENT || mode == st_pkg::MODE_NUM ||
                           mode == st_pkg::MODE_SLASH);
    s_valid = (do_start && !st_pkg::is_space(c) && !st_pkg::is_alpha(c) &&
               !st_pkg::is_digit(c) && c != st_pkg::CHAR_SLASH) ||
              (c == st_pkg::CHAR_NUL && (mode == st_pkg::MODE_LINE_COMMENT ||
               mode == st_pkg::MODE_BLOCK_COMMENT || mode == st_pkg::MODE_BLOCK_STAR));
    f_valid = s_tlast && (mode_next == st_pkg::MODE_IDENT ||
                          mode_next == st_pkg::MODE_NUM ||
                          mode_next == st_pkg::MODE_SLASH);

    tok_b.line   = line_count;
    tok_b.start  = run_start;
    tok_b.last   = 1'b0;
    tok_b.length = '0;
    if (mode == st_pkg::MODE_IDENT) begin
      tok_b.kind = st_pkg::word_kind(prefix, run_length);
      if (tok_b.kind == st_pkg::KIND_IDENT) tok_b.length = run_length;
    end else if (mode == st_pkg::MODE_NUM) begin
      tok_b.kind   = st_pkg::KIND_NUMBER;
      tok_b.length = run_length;
    end else begin
      tok_b.kind = st_pkg::KIND_SLASH;
    end

    tok_s.kind   = st_pkg::symbol_kind(c);
    tok_s.line   = line_count;
    tok_s.start  = byte_position;
    tok_s.length = '0;
    tok_s.last   = 1'b0;

    tok_f.line   = line_count;
    tok_f.start  = run_start_next;
    tok_f.last   = 1'b0;
    tok_f.length = '0;
    if (mode_next == st_pkg::MODE_IDENT) begin
      tok_f.kind = st_pkg::word_kind(prefix_next, run_length_next);
      if (tok_f.kind == st_pkg::KIND_IDENT) tok_f.length = run_length_next;
    end else if (mode_next == st_pkg::MODE_NUM) begin
      tok_f.kind   = st_pkg::KIND_NUMBER;
      tok_f.length = run_length_next;
    end else begin
      tok_f.kind = st_pkg::KIND_SLASH;
    end

    // a symbol leaves the mode idle or error, so s and f never both fire
    n_tok = 2'(b_valid) + 2'(s_valid) + 2'(f_valid);
    tok0  = b_valid ? tok_b : (s_valid ? tok_s : tok_f);
    tok1  = s_valid ? tok_s : tok_f;
    tok0.last = (n_tok == 2'd1);
    tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= st_pkg::MODE_IDLE;
      prefix        <= '0;
      run_length    <= '0;
      run_start     <= '0;
      byte_position <= '0;
      line_count    <= NW'(1);
    end else if (accept) begin
      if (s_tlast) begin
        mode          <= st_pkg::MODE_IDLE;
        prefix        <= '0;
        run_length    <= '0;
        run_start     <= '0;
        byte_position <= '0;
        line_count    <= NW'(1);
      end else begin
        mode       <= mode_next;
        prefix     <= prefix_next;
        run_length <= run_length_next;
        run_start  <= run_start_next;
        if (byte_position != {PW{1'b1}}) byte_position <= byte_position + PW'(1);
        if (newline && line_count != {NW{1'b1}}) line_count <= line_count + NW'(1);
      end
    end
  end

  // token queue
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= st_pkg::FIFO_CW'(st_pkg::FIFO_DEPTH - 2));
  assign m_tvalid = (count != '0);
  assign head     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + st_pkg::FIFO_AW'(n_tok);
      if (pop) rd_ptr <= rd_ptr + st_pkg::FIFO_AW'(1);
      count <= count + (accept ? st_pkg::FIFO_CW'(n_tok) : '0)
                     - st_pkg::FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_tok != 2'd0) fifo[wr_ptr] <= tok0;
    if (accept && n_tok == 2'd2) fifo[wr_ptr + st_pkg::FIFO_AW'(1)] <= tok1;
  end

  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {6'b0, st_pkg::prec_of(head.kind), head.length, head.start, head.line};

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the source tokenizer: byte streams in, token checks out.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 8000000;

  typedef struct {
    st_pkg::kind_t                     kind;
    logic [st_pkg::LINE_WIDTH-1:0]     line;
    logic [st_pkg::POSITION_WIDTH-1:0] start;
    logic [st_pkg::LENGTH_WIDTH-1:0]   length;
    st_pkg::prec_t                     prec;
    logic                              last;
  } lexed_token_t;

  class token_board;
    st_pkg::mode_t                     mode;
    logic [st_pkg::PREFIX_WIDTH-1:0]   prefix;
    logic [st_pkg::LENGTH_WIDTH-1:0]   run_len;
    logic [st_pkg::POSITION_WIDTH-1:0] run_start;
    logic [st_pkg::POSITION_WIDTH-1:0] pos;
    logic [st_pkg::LINE_WIDTH-1:0]     line;
    lexed_token_t                      due_tokens[$];
    lexed_token_t                      fresh[2];
    int                                fresh_n;
    int                                mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      mode      = st_pkg::MODE_IDLE;
      prefix    = '0;
      run_len   = '0;
      run_start = '0;
      pos       = '0;
      line      = st_pkg::LINE_WIDTH'(1);
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // a byte makes at most two tokens; only the final one carries last
    function void push_token(st_pkg::kind_t k, logic [st_pkg::POSITION_WIDTH-1:0] at,
                             logic [st_pkg::LENGTH_WIDTH-1:0] len);
      lexed_token_t t;
      if (fresh_n >= 2) return;
      if (fresh_n > 0) fresh[fresh_n-1].last = 1'b0;
      t.kind   = k;
      t.line   = line;
      t.start  = at;
      t.length = len;
      t.last   = 1'b1;
      case (k)
        st_pkg::KIND_PLUS, st_pkg::KIND_MINUS: t.prec = st_pkg::PREC_ADD;
        st_pkg::KIND_STAR, st_pkg::KIND_SLASH: t.prec = st_pkg::PREC_MUL;
        default:                               t.prec = st_pkg::PREC_NONE;
      endcase
      fresh[fresh_n] = t;
      fresh_n++;
    endfunction

    function void close_word();
      st_pkg::kind_t k;
      k = st_pkg::KIND_IDENT;
      if (run_len == 4 && prefix == st_pkg::WORD_EXIT)      k = st_pkg::KIND_EXIT;
      else if (run_len == 3 && prefix == st_pkg::WORD_LET)  k = st_pkg::KIND_LET;
      else if (run_len == 2 && prefix == st_pkg::WORD_IF)   k = st_pkg::KIND_IF;
      else if (run_len == 4 && prefix == st_pkg::WORD_ELIF) k = st_pkg::KIND_ELIF;
      else if (run_len == 4 && prefix == st_pkg::WORD_ELSE) k = st_pkg::KIND_ELSE;
      push_token(k, run_start, (k == st_pkg::KIND_IDENT) ? run_len : '0);
    endfunction

    function void grow(logic [7:0] c);
      if (run_len < 4) prefix |= st_pkg::PREFIX_WIDTH'(c) << (8 * run_len);
      if (run_len != '1) run_len++;
    endfunction

    function void bump_line();
      if (line != '1) line++;
    endfunction

    function void fail_byte();
      push_token(st_pkg::KIND_ERROR, pos, '0);
      mode = st_pkg::MODE_ERROR;
    endfunction

    function void open_byte(logic [7:0] c);
      st_pkg::kind_t k;
      mode = st_pkg::MODE_IDLE;
      if (is_blank(c)) begin
        if (c == st_pkg::CHAR_LF) bump_line();
      end else if (is_letter(c) || is_numeral(c)) begin
        mode      = is_letter(c) ? st_pkg::MODE_IDENT : st_pkg::MODE_NUM;
        run_start = pos;
        run_len   = '0;
        prefix    = '0;
        grow(c);
      end else if (c == st_pkg::CHAR_SLASH) begin
        mode      = st_pkg::MODE_SLASH;
        run_start = pos;
      end else begin
        case (c)
          st_pkg::CHAR_SEMI:   k = st_pkg::KIND_SEMI;
          st_pkg::CHAR_LPAREN: k = st_pkg::KIND_LPAREN;
          st_pkg::CHAR_RPAREN: k = st_pkg::KIND_RPAREN;
          st_pkg::CHAR_EQ:     k = st_pkg::KIND_EQ;
          st_pkg::CHAR_PLUS:   k = st_pkg::KIND_PLUS;
          st_pkg::CHAR_STAR:   k = st_pkg::KIND_STAR;
          st_pkg::CHAR_MINUS:  k = st_pkg::KIND_MINUS;
          st_pkg::CHAR_LBRACE: k = st_pkg::KIND_LBRACE;
          st_pkg::CHAR_RBRACE: k = st_pkg::KIND_RBRACE;
          default:             k = st_pkg::KIND_ERROR;
        endcase
        if (k == st_pkg::KIND_ERROR) fail_byte();
        else push_token(k, pos, '0);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic eos);
      fresh_n = 0;
      case (mode)
        st_pkg::MODE_ERROR: ;
        st_pkg::MODE_IDENT: begin
          if (is_letter(c) || is_numeral(c)) grow(c);
          else begin
            close_word();
            open_byte(c);
          end
        end
        st_pkg::MODE_NUM: begin
          if (is_numeral(c)) grow(c);
          else begin
            push_token(st_pkg::KIND_NUMBER, run_start, run_len);
            open_byte(c);
          end
        end
        st_pkg::MODE_SLASH: begin
          if (c == st_pkg::CHAR_SLASH) mode = st_pkg::MODE_LINE_COMMENT;
          else if (c == st_pkg::CHAR_STAR) mode = st_pkg::MODE_BLOCK_COMMENT;
          else begin
            push_token(st_pkg::KIND_SLASH, run_start, '0);
            open_byte(c);
          end
        end
        st_pkg::MODE_LINE_COMMENT: begin
          if (c == st_pkg::CHAR_NUL) fail_byte();
          else if (c == st_pkg::CHAR_LF) begin
            mode = st_pkg::MODE_IDLE;
            bump_line();
          end
        end
        st_pkg::MODE_BLOCK_COMMENT, st_pkg::MODE_BLOCK_STAR: begin
          if (c == st_pkg::CHAR_NUL) fail_byte();
          else if (c == st_pkg::CHAR_STAR) mode = st_pkg::MODE_BLOCK_STAR;
          else if (c == st_pkg::CHAR_SLASH && mode == st_pkg::MODE_BLOCK_STAR)
            mode = st_pkg::MODE_IDLE;
          else mode = st_pkg::MODE_BLOCK_COMMENT;
        end
        default: open_byte(c);
      endcase
      if (pos != '1) pos++;
      if (eos) begin
        if (mode == st_pkg::MODE_IDENT) close_word();
        else if (mode == st_pkg::MODE_NUM) push_token(st_pkg::KIND_NUMBER, run_start, run_len);
        else if (mode == st_pkg::MODE_SLASH) push_token(st_pkg::KIND_SLASH, run_start, '0);
        restart();
      end
      for (int i = 0; i < fresh_n; i++) due_tokens.insert(due_tokens.size(), fresh[i]);
    endfunction

    function void check_token(logic [4:0] user, logic [79:0] data, logic last);
      lexed_token_t e;
      if (due_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d line %0d start %0d len %0d",
                   user, data[23:0], data[55:24], data[71:56]);
        return;
      end
      e = due_tokens.pop_front();
      if (user !== e.kind || data[23:0] !== e.line || data[55:24] !== e.start ||
          data[71:56] !== e.length || data[73:72] !== e.prec ||
          data[79:74] !== 6'd0 || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("token mismatch: exp kind %0d line %0d start %0d len %0d prec %0d last %0b",
                   e.kind, e.line, e.start, e.length, e.prec, e.last);
          $display("  got kind %0d line %0d start %0d len %0d prec %0d last %0b pad %0h",
                   user, data[23:0], data[55:24], data[71:56], data[73:72],
                   last, data[79:74]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  token_board  board;
  logic [7:0]  src_bytes[$];
  int          live_items;
  int          gap_pct;
  int          hold_pct;
  int          hold_left;
  int          cycles;
  bit          calm;

  source_tokenizer DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output backpressure in bursts, none once calm is set
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < hold_pct) begin
      hold_left = $urandom_range(1, 11) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_token(m_tuser, m_tdata, m_tlast);
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_byte(b, eos);
    live_items++;
  endtask

  // sends the pending source text, end marker on its final byte
  task automatic flush_source();
    for (int i = 0; i < src_bytes.size(); i++)
      send_byte(src_bytes[i], i == src_bytes.size() - 1);
    src_bytes.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int j = 0; j < s.len(); j++) add_byte(s[j]);
  endtask

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  function automatic logic [7:0] pick_alnum();
    return $urandom_range(0, 2) == 0 ? 8'($urandom_range(48, 57)) : pick_letter();
  endfunction

  task automatic add_piece();
    string       words[5];
    string       symbols;
    logic [7:0]  c;
    int          n;
    words   = '{"exit", "let", "if", "elif", "else"};
    symbols = ";()=+*-{}";
    case ($urandom_range(0, 19))
      0, 1: begin
        add_text(words[$urandom_range(0, 4)]);
        // near misses: changed or extra character
        if ($urandom_range(0, 3) == 0) src_bytes[src_bytes.size()-1] = pick_letter();
        else if ($urandom_range(0, 4) == 0) add_byte(pick_alnum());
      end
      2, 3, 4: begin
        add_byte(pick_letter());
        repeat ($urandom_range(0, 7)) add_byte(pick_alnum());
      end
      5, 6: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(48, 57)));
      7, 8, 9: add_byte(symbols[$urandom_range(0, 8)]);
      10: add_byte(st_pkg::CHAR_SLASH);
      11, 12, 13: repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(0, 5);
        add_byte(n == 0 ? 8'd32 : 8'(8 + n));
      end
      14: begin
        add_text("//");
        repeat ($urandom_range(0, 8)) begin
          c = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(32, 126));
          add_byte(c == st_pkg::CHAR_LF ? 8'd32 : c);
        end
        add_byte(st_pkg::CHAR_LF);
      end
      15, 16: begin
        add_text("/*");
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0, 1: c = st_pkg::CHAR_STAR;
            2:    c = st_pkg::CHAR_SLASH;
            3:    c = st_pkg::CHAR_LF;
            4:    c = 8'($urandom_range(1, 255));
            default: c = pick_alnum();
          endcase
          add_byte(c);
        end
        add_text("*/");
      end
      17: add_byte($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255)) : 8'd32);
      default: add_byte(8'd32);
    endcase
  endtask

  task automatic random_sources(input int goal);
    int cut;
    live_items = 0;
    while (live_items < goal) begin
      gap_pct  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 30);
      hold_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 30);
      repeat ($urandom_range(1, 16)) add_piece();
      // sometimes cut the text short, ending inside a token or a comment
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, src_bytes.size());
        while (src_bytes.size() > cut) src_bytes.delete(src_bytes.size() - 1);
      end
      flush_source();
    end
  endtask

  initial begin
    board    = new();
    gap_pct  = 0;
    hold_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_text("elif{A=(0+9)*1-Z/3;}");
    flush_source();
    add_text("/*/*/");
    flush_source();
    add_byte(8'hFF);
    flush_source();
    add_text("a");
    add_byte(st_pkg::CHAR_NUL);
    flush_source();
    add_text("//");
    add_byte(st_pkg::CHAR_NUL);
    flush_source();
    add_text("/*");
    flush_source();

    random_sources(490);
    random_sources(60);
    calm = 1'b1;
    random_sources(120);

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
